// File: design/bmp_rgba_stream_reader_assert.svh
// Assertion macros shared by the BMP reader modules.
// Each macro expects signals named clock and reset in the including scope.
`ifndef BMP_RGBA_STREAM_READER_ASSERT_SVH
`define BMP_RGBA_STREAM_READER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BMPRD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define BMPRD_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);
`else
`define BMPRD_ASSERT_IMPLY(label, ante, cons, msg)
`define BMPRD_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// File: design/bmprd_pkg.sv
// Types and constants of the BMP reader: status codes, queue entry, header constants.
// No dependencies.
`default_nettype none
package bmprd_pkg;

   localparam int COORD_W      = 12;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
   localparam logic [7:0]  HEADER_BYTES = 8'd54;
   localparam logic [7:0]  PIXEL_BITS   = 8'd32;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_MAGIC  = 3'd1,
      ST_BAD_FORMAT = 3'd2,
      ST_TRUNCATED  = 3'd3,
      ST_BAD_OFFSET = 3'd4
   } status_type;

   typedef struct packed {
      logic               has_pixel;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               has_status;
      status_type         status;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    avail;
      cmd_type cmd;
   } head_type;

endpackage
`default_nettype wire

// File: design/bmprd_req_if.sv
// Byte input channel of the BMP reader: valid/ready with one file byte.
// No dependencies.
`default_nettype none
interface bmprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface
`default_nettype wire

// File: design/bmprd_rsp_if.sv
// Result channel of the BMP reader: valid/ready with a pixel or status result.
// No dependencies.
`default_nettype none
interface bmprd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [11:0] column;
   logic [11:0] row;
   logic [2:0]  status;
   logic        end_mark;

   modport source (output valid, output kind, output red, output green, output blue,
                   output alpha, output column, output row, output status,
                   output end_mark, input ready);
   modport sink   (input valid, input kind, input red, input green, input blue,
                   input alpha, input column, input row, input status,
                   input end_mark, output ready);
endinterface
`default_nettype wire

// File: design/bmprd_queue.sv
// Short command queue between the byte parser and the result formatter.
// Depends on bmprd_pkg and the assertion macro header.
`default_nettype none
`include "bmp_rgba_stream_reader_assert.svh"
module bmprd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bmprd_pkg::push_type push,
   input  wire logic               pop,
   output bmprd_pkg::head_type     head,
   output logic                    full
);
   import bmprd_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assign head.avail = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];
   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   `BMPRD_ASSERT_NEVER(a_push_when_full, push.valid && full, "queue written while full")
   `BMPRD_ASSERT_NEVER(a_pop_when_empty, pop && !head.avail, "queue read while empty")

endmodule
`default_nettype wire

// File: design/bmprd_front.sv
// Byte parser of the BMP reader: header capture and checks, pixel assembly, end status.
// Depends on bmprd_pkg, bmprd_req_if and the assertion macro header.
`default_nettype none
`include "bmp_rgba_stream_reader_assert.svh"
module bmprd_front #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic           clock,
   input  wire logic           reset,
   bmprd_req_if.sink           req_chan,
   input  wire logic           queue_full,
   output bmprd_pkg::push_type push
);
   import bmprd_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int X_W   = $clog2(MAX_DIM);

   localparam logic [5:0] POS_MAGIC  = 6'd1;
   localparam logic [5:0] POS_OFFSET = 6'd13;
   localparam logic [5:0] POS_WIDTH  = 6'd21;
   localparam logic [5:0] POS_HEIGHT = 6'd25;
   localparam logic [5:0] POS_PLANES = 6'd27;
   localparam logic [5:0] POS_BPP    = 6'd29;
   localparam logic [5:0] POS_COMP   = 6'd33;

   function automatic logic [1:0] field_lane(input logic [5:0] pos);
      logic [1:0] lane;
      if (pos < 6'd2) begin
         lane = pos[1:0];
      end else if (pos < 6'd26) begin
         lane = pos[1:0] - 2'd2;
      end else if (pos < 6'd28) begin
         lane = pos[1:0] - 2'd2;
      end else if (pos < 6'd30) begin
         lane = pos[1:0];
      end else if (pos < 6'd34) begin
         lane = pos[1:0] - 2'd2;
      end else begin
         lane = 2'd0;
      end
      return lane;
   endfunction

   logic [31:0]      byte_count_ff, byte_count_in;
   logic [31:0]      field_ff, field_in;
   logic [31:0]      data_start_ff, data_start_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             top_down_ff, top_down_in;
   status_type       err_ff, err_in;
   logic [23:0]      quad_ff, quad_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [DIM_W-1:0] y_ff, y_in;

   logic             accept;
   logic [5:0]       pos;
   logic [1:0]       lane;
   logic [31:0]      byte_wide;
   logic [31:0]      field_val;
   logic [31:0]      magnitude;
   status_type       hdr_err;
   logic [1:0]       pix_lane;
   logic [DIM_W-1:0] x_next;
   logic [DIM_W-1:0] row_full;
   logic [7:0]       b;
   status_type       end_status;

   assign accept    = req_chan.valid && req_chan.ready;
   assign b         = req_chan.byte_value;
   assign byte_wide = 32'(b);
   assign pos       = byte_count_ff[5:0];
   assign lane      = field_lane(pos);
   assign field_val = (lane == 2'd0) ? byte_wide
                                     : (field_ff | (byte_wide << {lane, 3'b000}));
   assign magnitude = field_val[31] ? (~field_val + 32'd1) : field_val;
   assign pix_lane  = byte_count_ff[1:0] - data_start_ff[1:0];
   assign x_next    = DIM_W'(x_ff) + DIM_W'(1);
   assign row_full  = top_down_ff ? y_ff : (height_ff - DIM_W'(1) - y_ff);

   always_comb begin
      byte_count_in = byte_count_ff;
      field_in      = field_ff;
      data_start_in = data_start_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      top_down_in   = top_down_ff;
      err_in        = err_ff;
      quad_in       = quad_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      hdr_err       = ST_OK;
      end_status    = ST_OK;
      push          = '0;

      if (accept) begin
         if (byte_count_ff < 32'(HEADER_BYTES)) begin
            field_in = field_val;
            case (pos)
               POS_MAGIC: begin
                  if (field_val != 32'(BMP_MAGIC)) hdr_err = ST_BAD_MAGIC;
               end
               POS_OFFSET: begin
                  data_start_in = field_val;
                  if (field_val < 32'(HEADER_BYTES)) hdr_err = ST_BAD_OFFSET;
               end
               POS_WIDTH: begin
                  if (field_val[31] || field_val == 32'd0 || field_val > 32'(MAX_DIM)) begin
                     hdr_err  = ST_BAD_FORMAT;
                     width_in = '0;
                  end else begin
                     width_in = DIM_W'(field_val);
                  end
               end
               POS_HEIGHT: begin
                  top_down_in = field_val[31];
                  if (magnitude == 32'd0 || magnitude > 32'(MAX_DIM)) begin
                     hdr_err   = ST_BAD_FORMAT;
                     height_in = '0;
                  end else begin
                     height_in = DIM_W'(magnitude);
                  end
               end
               POS_PLANES: begin
                  if (field_val != 32'd1) hdr_err = ST_BAD_FORMAT;
               end
               POS_BPP: begin
                  if (field_val != 32'(PIXEL_BITS)) hdr_err = ST_BAD_FORMAT;
               end
               POS_COMP: begin
                  if (field_val != 32'd0) hdr_err = ST_BAD_FORMAT;
               end
               default: begin
                  hdr_err = ST_OK;
               end
            endcase
            if (err_ff == ST_OK) err_in = hdr_err;
         end else if (err_ff == ST_OK && byte_count_ff >= data_start_ff &&
                      y_ff < height_ff) begin
            case (pix_lane)
               2'd0: quad_in = {16'b0, b};
               2'd1: quad_in = quad_ff | {8'b0, b, 8'b0};
               2'd2: quad_in = quad_ff | {b, 16'b0};
               default: begin
                  push.cmd.has_pixel = 1'b1;
                  push.cmd.red       = quad_ff[23:16];
                  push.cmd.green     = quad_ff[15:8];
                  push.cmd.blue      = quad_ff[7:0];
                  push.cmd.alpha     = b;
                  push.cmd.column    = COORD_W'(x_ff);
                  push.cmd.row       = COORD_W'(row_full);
                  if (x_next >= width_ff) begin
                     x_in = '0;
                     y_in = y_ff + DIM_W'(1);
                  end else begin
                     x_in = X_W'(x_next);
                  end
               end
            endcase
         end

         if (byte_count_ff != '1) byte_count_in = byte_count_ff + 32'd1;

         if (req_chan.last_byte) begin
            end_status = err_in;
            if (end_status == ST_OK &&
                (byte_count_in < 32'(HEADER_BYTES) || y_in < height_in)) begin
               end_status = ST_TRUNCATED;
            end
            push.cmd.has_status = 1'b1;
            push.cmd.status     = end_status;
            byte_count_in = '0;
            field_in      = '0;
            data_start_in = '0;
            width_in      = '0;
            height_in     = '0;
            top_down_in   = 1'b0;
            err_in        = ST_OK;
            quad_in       = '0;
            x_in          = '0;
            y_in          = '0;
         end
         push.valid = push.cmd.has_pixel || push.cmd.has_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         field_ff      <= '0;
         data_start_ff <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         top_down_ff   <= 1'b0;
         err_ff        <= ST_OK;
         quad_ff       <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         field_ff      <= field_in;
         data_start_ff <= data_start_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         top_down_ff   <= top_down_in;
         err_ff        <= err_in;
         quad_ff       <= quad_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
      end
   end

   assign req_chan.ready = !queue_full;

   `BMPRD_ASSERT_IMPLY(a_no_pixel_after_error, push.valid && push.cmd.has_pixel,
                       err_ff == ST_OK, "pixel issued after a header error")

endmodule
`default_nettype wire

// File: design/bmprd_back.sv
// Result formatter of the BMP reader: drains the queue into the output register.
// Depends on bmprd_pkg, bmprd_rsp_if and the assertion macro header.
`default_nettype none
`include "bmp_rgba_stream_reader_assert.svh"
module bmprd_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bmprd_pkg::head_type head,
   output logic                pop,
   bmprd_rsp_if.source         rsp_chan
);
   import bmprd_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      status_type         status;
      logic               end_mark;
   } result_type;

   function automatic result_type status_result(input status_type st);
      result_type r;
      r          = '0;
      r.kind     = KIND_STATUS;
      r.status   = st;
      r.end_mark = 1'b1;
      return r;
   endfunction

   function automatic result_type pixel_result(input cmd_type c);
      result_type r;
      r        = '0;
      r.kind   = KIND_PIXEL;
      r.red    = c.red;
      r.green  = c.green;
      r.blue   = c.blue;
      r.alpha  = c.alpha;
      r.column = c.column;
      r.row    = c.row;
      r.status = ST_OK;
      return r;
   endfunction

   logic       out_valid_ff, out_valid_in;
   result_type res_ff, res_in;
   logic       pend_ff, pend_in;
   status_type pend_st_ff, pend_st_in;
   logic       load;

   assign load = !out_valid_ff || rsp_chan.ready;
   assign pop  = load && !pend_ff && head.avail;

   always_comb begin
      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      pend_in      = pend_ff;
      pend_st_in   = pend_st_ff;
      if (load) begin
         if (pend_ff) begin
            res_in       = status_result(pend_st_ff);
            pend_in      = 1'b0;
            out_valid_in = 1'b1;
         end else if (head.avail) begin
            if (head.cmd.has_pixel) begin
               res_in     = pixel_result(head.cmd);
               pend_in    = head.cmd.has_status;
               pend_st_in = head.cmd.status;
            end else begin
               res_in = status_result(head.cmd.status);
            end
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      pend_st_ff <= pend_st_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.kind     = res_ff.kind;
   assign rsp_chan.red      = res_ff.red;
   assign rsp_chan.green    = res_ff.green;
   assign rsp_chan.blue     = res_ff.blue;
   assign rsp_chan.alpha    = res_ff.alpha;
   assign rsp_chan.column   = res_ff.column;
   assign rsp_chan.row      = res_ff.row;
   assign rsp_chan.status   = res_ff.status;
   assign rsp_chan.end_mark = res_ff.end_mark;

   `BMPRD_ASSERT_IMPLY(a_pend_needs_pixel, pend_ff,
                       out_valid_ff && res_ff.kind == KIND_PIXEL,
                       "status pending without a held pixel")

endmodule
`default_nettype wire

// File: design/bmp_rgba_stream_reader.sv
// Top level of the streaming 32-bit BMP reader.
// Depends on bmprd_pkg, bmprd_req_if, bmprd_rsp_if, bmprd_front, bmprd_queue, bmprd_back.
`default_nettype none
// Takes one file byte per clock, checks the header and emits each BGRA pixel as an
// RGBA result with its column and destination row as soon as its fourth byte arrives;
// the last byte of a file closes it with a status result (0 ok, 1 bad magic, 2 bad
// format, 3 truncated, 4 bad pixel offset), after which the next byte starts a new
// file. The parser handles each accepted byte and hands its results to a four-entry
// queue; the formatter drains the queue into a registered output at one result per
// cycle while the output is not stalled, so a byte that completes a pixel and ends
// the file gives a pixel result, then a status result. Input ready drops only while
// that queue is full, which happens only when the result side stalls. On a non-ok
// status the pixels already sent are to be discarded. No clearing pass follows reset.
module bmp_rgba_stream_reader #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bmprd_req_if.sink   req_chan,
   bmprd_rsp_if.source rsp_chan
);
   import bmprd_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   bmprd_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .queue_full(queue_full),
      .push      (push)
   );

   bmprd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .head (head),
      .full (queue_full)
   );

   bmprd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_chan(rsp_chan)
   );

endmodule
`default_nettype wire

// File: tb/bmp_pixel_checker.sv
`timescale 1ns / 100ps
// Checker for the streaming BMP reader: predicts every pixel and status transfer from
// the accepted file bytes and compares each result transfer with the oldest prediction.
// Depends on bmprd_pkg, bmprd_req_if and bmprd_rsp_if.
module bmp_pixel_checker #(
   parameter int MAX_DIM = 4096
) (
   input  logic clock,
   input  logic reset,
   bmprd_req_if req_chan,
   bmprd_rsp_if rsp_chan,
   output int   fail_count,
   output int   open_results
);
   import bmprd_pkg::*;

   localparam int MAGIC_LAST       = 1;
   localparam int OFFSET_LAST      = 13;
   localparam int WIDTH_LAST       = 21;
   localparam int HEIGHT_LAST      = 25;
   localparam int PLANES_LAST      = 27;
   localparam int BPP_LAST         = 29;
   localparam int COMPRESSION_LAST = 33;

   typedef struct packed {
      logic        kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] column;
      logic [11:0] row;
      status_type  status;
      logic        end_mark;
   } rgba_result_type;

   rgba_result_type due_results[$];
   int mismatches = 0;

   logic [31:0] byte_count;
   logic [31:0] field_acc;
   logic [31:0] data_start;
   logic [31:0] image_width;
   logic [31:0] image_height;
   logic        top_first;
   status_type  error_code;
   logic [23:0] quad_bytes;
   logic [12:0] x_count;
   logic [12:0] y_count;

   task automatic clear_file_state();
      byte_count   = '0;
      field_acc    = '0;
      data_start   = '0;
      image_width  = '0;
      image_height = '0;
      top_first    = 1'b0;
      error_code   = ST_OK;
      quad_bytes   = '0;
      x_count      = '0;
      y_count      = '0;
   endtask

   function automatic logic [31:0] field_start(input logic [31:0] pos);
      if (pos < 2) return 0;
      if (pos < 26) return 2 + ((pos - 2) / 4) * 4;
      if (pos < 28) return 26;
      if (pos < 30) return 28;
      if (pos < 34) return 30;
      return pos;
   endfunction

   // keep the first error of the file
   task automatic flag_error(input status_type code);
      if (error_code == ST_OK) error_code = code;
   endtask

   task automatic take_header_byte(input logic [31:0] pos, input logic [7:0] b);
      logic [31:0] start;
      logic [31:0] v;
      logic [31:0] mag;
      start = field_start(pos);
      if (pos == start) field_acc = {24'd0, b};
      else field_acc |= {24'd0, b} << (8 * ((pos - start) & 32'd3));
      v = field_acc;
      case (pos)
         MAGIC_LAST: if (v != {16'd0, BMP_MAGIC}) flag_error(ST_BAD_MAGIC);
         OFFSET_LAST: begin
            data_start = v;
            if (v < HEADER_BYTES) flag_error(ST_BAD_OFFSET);
         end
         WIDTH_LAST: begin
            if (v[31] || v == 0 || v > MAX_DIM) begin
               flag_error(ST_BAD_FORMAT);
               image_width = '0;
            end else begin
               image_width = v;
            end
         end
         HEIGHT_LAST: begin
            mag = v;
            top_first = 1'b0;
            if (v[31]) begin
               mag = -v;
               top_first = 1'b1;
            end
            if (mag == 0 || mag > MAX_DIM) begin
               flag_error(ST_BAD_FORMAT);
               image_height = '0;
            end else begin
               image_height = mag;
            end
         end
         PLANES_LAST: if (v != 1) flag_error(ST_BAD_FORMAT);
         BPP_LAST: if (v != PIXEL_BITS) flag_error(ST_BAD_FORMAT);
         COMPRESSION_LAST: if (v != 0) flag_error(ST_BAD_FORMAT);
         default: ;
      endcase
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      rgba_result_type r;
      logic [31:0] phase;
      logic [31:0] dest_row;
      if (byte_count < HEADER_BYTES) begin
         take_header_byte(byte_count, b);
      end else if (error_code == ST_OK && byte_count >= data_start &&
                   y_count < image_height) begin
         phase = (byte_count - data_start) & 32'd3;
         if (phase == 0) begin
            quad_bytes = {16'd0, b};
         end else if (phase < 3) begin
            quad_bytes |= {16'd0, b} << (8 * phase);
         end else begin
            dest_row = top_first ? 32'(y_count) : image_height - 1 - y_count;
            r = '0;
            r.kind   = KIND_PIXEL;
            r.red    = quad_bytes[23:16];
            r.green  = quad_bytes[15:8];
            r.blue   = quad_bytes[7:0];
            r.alpha  = b;
            r.column = x_count[11:0];
            r.row    = dest_row[11:0];
            r.status = ST_OK;
            due_results = {due_results, r};
            x_count++;
            if (x_count >= image_width) begin
               x_count = '0;
               y_count++;
            end
         end
      end
      if (byte_count != '1) byte_count++;
      if (last) begin
         r = '0;
         r.kind     = KIND_STATUS;
         r.status   = error_code;
         r.end_mark = 1'b1;
         if (error_code == ST_OK && (byte_count < HEADER_BYTES || y_count < image_height))
            r.status = ST_TRUNCATED;
         due_results = {due_results, r};
         clear_file_state();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_result();
      rgba_result_type want;
      if (due_results.size() == 0) begin
         $error("unexpected result: kind %0d status %0d column %0d row %0d",
                rsp_chan.kind, rsp_chan.status, rsp_chan.column, rsp_chan.row);
         mismatches++;
      end else begin
         want = due_results.pop_front();
         check_field("kind", want.kind, rsp_chan.kind);
         check_field("red", want.red, rsp_chan.red);
         check_field("green", want.green, rsp_chan.green);
         check_field("blue", want.blue, rsp_chan.blue);
         check_field("alpha", want.alpha, rsp_chan.alpha);
         check_field("column", want.column, rsp_chan.column);
         check_field("row", want.row, rsp_chan.row);
         check_field("status", want.status, rsp_chan.status);
         check_field("end_mark", want.end_mark, rsp_chan.end_mark);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_file_state();
         due_results.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            take_byte(req_chan.byte_value, req_chan.last_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            compare_result();
      end
      open_results <= due_results.size();
      fail_count   <= mismatches;
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the BMP reader testbench: builds directed and random BMP byte streams, drives
// them with random gaps and result stalls, and reports the verdict from the checker.
// Depends on bmprd_pkg, the channel interfaces, bmp_rgba_stream_reader, bmp_pixel_checker.
module tb;
   import bmprd_pkg::*;

   localparam int          MAX_DIM           = 4096;
   localparam logic [31:0] INFO_HEADER_BYTES = 32'd40;
   localparam int          RANDOM_BYTES      = 750;
   localparam int          RESET_CYCLES      = 12;
   localparam int          STALL_CYCLES      = 200;
   localparam int          WATCHDOG_LIMIT    = 2000;
   localparam int          SETTLE_CYCLES     = 16;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   open_results;
   int   quiet_cycles = 0;
   int   sent_bytes = 0;
   logic sender_burst = 1'b0;
   logic [7:0] file_buf[$];

   bmprd_req_if req_chan();
   bmprd_rsp_if rsp_chan();

   bmp_rgba_stream_reader #(.MAX_DIM(MAX_DIM)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   bmp_pixel_checker #(.MAX_DIM(MAX_DIM)) pixel_check (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .fail_count(fail_count),
      .open_results(open_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int draw_wait(input logic burst);
      return burst ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic append_byte(input logic [7:0] v);
      file_buf = {file_buf, v};
   endtask

   task automatic put_word(input logic [31:0] v, input int nbytes);
      for (int i = 0; i < nbytes; i++) append_byte(v[8*i +: 8]);
   endtask

   task automatic make_header(input logic [15:0] magic, input logic [31:0] offset,
                              input logic [31:0] width, input logic [31:0] height,
                              input logic [15:0] planes, input logic [15:0] bpp,
                              input logic [31:0] compression);
      file_buf.delete();
      put_word(magic, 2);
      put_word($urandom, 4);
      put_word($urandom, 4);
      put_word(offset, 4);
      put_word(INFO_HEADER_BYTES, 4);
      put_word(width, 4);
      put_word(height, 4);
      put_word(planes, 2);
      put_word(bpp, 2);
      put_word(compression, 4);
      repeat (HEADER_BYTES - file_buf.size()) append_byte(8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_wait(sender_burst);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.byte_value <= b;
      req_chan.last_byte  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_file();
      sender_burst = ($urandom_range(0, 3) == 0);
      foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
      sent_bytes += file_buf.size();
   endtask

   // tail < 0 cuts bytes off the end, tail > 0 appends trailing bytes
   task automatic run_file(input logic [15:0] magic, input logic [31:0] offset,
                           input logic [31:0] width, input logic [31:0] height,
                           input logic [15:0] planes, input logic [15:0] bpp,
                           input logic [31:0] compression, input int pixels, input int tail);
      make_header(magic, offset, width, height, planes, bpp, compression);
      if (offset > HEADER_BYTES && offset <= HEADER_BYTES + 8)
         repeat (offset - HEADER_BYTES) append_byte(8'($urandom));
      repeat (4 * pixels) append_byte(8'($urandom));
      if (tail < 0) repeat (-tail) void'(file_buf.pop_back());
      else repeat (tail) append_byte(8'($urandom));
      send_file();
   endtask

   task automatic random_file();
      int w;
      int h;
      int pad;
      int pick;
      int pos;
      logic [31:0] h_field;
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 3);
      pad = $urandom_range(0, 6);
      pick = $urandom_range(0, 9);
      h_field = $urandom_range(0, 1) ? -h : h;
      make_header(BMP_MAGIC, HEADER_BYTES + pad, w, h_field, 1, PIXEL_BITS, 0);
      repeat (pad + 4 * w * h) append_byte(8'($urandom));
      case (pick)
         6: repeat ($urandom_range(1, 5)) append_byte(8'($urandom));
         7: repeat ($urandom_range(1, file_buf.size() - 1)) void'(file_buf.pop_back());
         8: begin
            pos = $urandom_range(0, 33);
            file_buf[pos] = file_buf[pos] ^ 8'($urandom_range(1, 255));
         end
         9: begin
            file_buf.delete();
            repeat ($urandom_range(1, 60)) append_byte(8'($urandom));
         end
         default: ;
      endcase
      send_file();
   endtask

   initial begin
      int base;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.byte_value <= 8'h00;
      req_chan.last_byte  <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // good bottom-up file ending on its last pixel, extreme channel values
      make_header(BMP_MAGIC, HEADER_BYTES, 2, 2, 1, PIXEL_BITS, 0);
      repeat (4) append_byte(8'h00);
      repeat (4) append_byte(8'hFF);
      for (int i = 1; i <= 4; i++) append_byte(8'(i * 17));
      repeat (4) append_byte(8'($urandom));
      send_file();

      run_file(BMP_MAGIC, HEADER_BYTES + 2, 3, -1, 1, PIXEL_BITS, 0, 3, 3);
      run_file(16'h424D, HEADER_BYTES, 2, 2, 2, PIXEL_BITS, 0, 4, 0);
      run_file(BMP_MAGIC, HEADER_BYTES - 1, 1, 1, 1, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 0, 1, 1, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, MAX_DIM + 1, 1, 1, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 32'hFFFF_FFFF, 1, 1, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 1, 0, 1, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 1, -(MAX_DIM + 1), 1, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 1, 32'h8000_0000, 1, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 1, 1, 0, PIXEL_BITS, 0, 1, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 1, 1, 1, 24, 0, 0, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 1, 1, 1, PIXEL_BITS, 3, 1, 0);
      run_file(BMP_MAGIC, 32'hFFFF_FFFF, 1, 1, 1, PIXEL_BITS, 0, 2, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 2, 2, 1, PIXEL_BITS, 0, 4, -17);
      run_file(BMP_MAGIC, HEADER_BYTES, 2, 2, 1, PIXEL_BITS, 0, 4, -5);
      file_buf.delete();
      append_byte(8'($urandom));
      send_file();
      run_file(BMP_MAGIC, HEADER_BYTES, MAX_DIM, -1, 1, PIXEL_BITS, 0, 3, 0);
      run_file(BMP_MAGIC, HEADER_BYTES, 1, MAX_DIM, 1, PIXEL_BITS, 0, 3, 0);

      base = sent_bytes;
      while (sent_bytes - base < RANDOM_BYTES) random_file();
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && open_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int gap;
      int taken;
      logic burst;
      taken = 0;
      burst = 1'b0;
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (taken % 64 == 0) burst = ($urandom_range(0, 3) == 0);
         gap = draw_wait(burst);
         // hold off long enough to fill the block and stall the byte input
         if (taken == 100 || taken == 6000) gap = STALL_CYCLES;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         taken++;
      end
   end

endmodule
